[sv/dsts_pkg.sv]
// Shared constants, codes and command/status types of the dual stack threshold sorter.
package dsts_pkg;

    localparam int DEFAULT_DEPTH = 64;

    localparam int VALUE_W    = 31;
    localparam int CAP_W      = 7;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 31;

    localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_CAPACITY  = 1'b1;

    localparam logic OP_PUSH   = 1'b0;
    localparam logic OP_FINISH = 1'b1;

    localparam logic [VALUE_W-1:0] THRESHOLD_RST = 31'd1000;
    localparam logic [CAP_W-1:0]   CAPACITY_RST  = 7'd64;

    typedef struct packed {
        logic push;
        logic start;
        logic read;
        logic advance;
        logic clear;
    } t_dp_cmd;

    typedef struct packed {
        logic empty;
        logic last;
    } t_dp_status;

endpackage

[sv/dsts_in_if.sv]
// Input channel of the sorter: valid/ready handshake with the op and value fields.
interface dsts_in_if import dsts_pkg::*; ();
    logic               valid;
    logic               ready;
    logic               op;
    logic [VALUE_W-1:0] value;

    modport source (output valid, output op, output value, input ready);
    modport sink   (input valid, input op, input value, output ready);
endinterface

[sv/dsts_out_if.sv]
// Result channel of the sorter: valid/ready handshake with one emitted entry.
interface dsts_out_if import dsts_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [VALUE_W-1:0] item_value;
    logic               from_large;
    logic               last;
    logic               dropped;

    modport source (output valid, output item_value, output from_large, output last,
                    output dropped, input ready);
    modport sink   (input valid, input item_value, input from_large, input last,
                    input dropped, output ready);
endinterface

[sv/dsts_ctrl.sv]
// Controller state machine that sequences pushes and the drain of both stacks.
module dsts_ctrl import dsts_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    input  logic       i_in_op,
    input  logic       i_out_ready,
    input  t_dp_status i_status,
    output logic       o_in_ready,
    output logic       o_out_valid,
    output t_dp_cmd    o_cmd
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_READ = 2'd1;
    localparam logic [1:0] ST_SHOW = 2'd2;

    logic [1:0] r_state;
    logic [1:0] n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state     = r_state;
        o_cmd       = '0;
        o_in_ready  = 1'b0;
        o_out_valid = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    if (i_in_op == OP_PUSH) begin
                        o_cmd.push = 1'b1;
                    end else if (i_status.empty) begin
                        o_cmd.clear = 1'b1;
                    end else begin
                        o_cmd.start = 1'b1;
                        n_state     = ST_READ;
                    end
                end
            end
            ST_READ: begin
                o_cmd.read = 1'b1;
                n_state    = ST_SHOW;
            end
            ST_SHOW: begin
                o_out_valid = 1'b1;
                if (i_out_ready) begin
                    if (i_status.last) begin
                        o_cmd.clear = 1'b1;
                        n_state     = ST_IDLE;
                    end else begin
                        o_cmd.advance = 1'b1;
                        n_state       = ST_READ;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

endmodule

[sv/dsts_datapath.sv]
// Datapath with the shared stack memory, stack sizes, drain pointer and output register.
module dsts_datapath import dsts_pkg::*; #(
    parameter int DEPTH = DEFAULT_DEPTH
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic [VALUE_W-1:0]    i_value,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  t_dp_cmd               i_cmd,
    output t_dp_status            o_status,
    output logic [VALUE_W-1:0]    o_item_value,
    output logic                  o_from_large,
    output logic                  o_last,
    output logic                  o_dropped
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [VALUE_W-1:0] mem [DEPTH];

    logic [VALUE_W-1:0] r_threshold;
    logic [CAP_W-1:0]   r_capacity;
    logic [CW-1:0]      r_small;
    logic [CW-1:0]      r_large;
    logic               r_overflow;
    logic [AW-1:0]      r_ptr;
    logic               r_phase;
    logic [VALUE_W-1:0] r_rd_data;
    logic               r_out_large;
    logic               r_out_last;

    logic [CW-1:0] w_cap;
    logic [CW-1:0] w_total;
    logic [CW-1:0] w_large_base;
    logic [CW-1:0] w_large_waddr;
    logic [CW-1:0] w_cap_m1;
    logic          w_full;
    logic          w_to_large;
    logic          w_cap_write;

    always_comb begin
        if (r_capacity == '0) begin
            w_cap = CW'(1);
        end else if (r_capacity > CAP_W'(DEPTH)) begin
            w_cap = CW'(DEPTH);
        end else begin
            w_cap = r_capacity[CW-1:0];
        end
    end

    assign w_total       = r_small + r_large;
    assign w_full        = (w_total >= w_cap);
    assign w_to_large    = (i_value > r_threshold);
    assign w_large_base  = w_cap - r_large;
    assign w_large_waddr = w_cap - r_large - CW'(1);
    assign w_cap_m1      = w_cap - CW'(1);
    assign w_cap_write   = i_cfg_we && (i_cfg_index == REG_CAPACITY);

    always_ff @(posedge i_clk) begin
        if (i_cmd.push && !w_full) begin
            if (w_to_large) begin
                mem[w_large_waddr[AW-1:0]] <= i_value;
            end else begin
                mem[r_small[AW-1:0]] <= i_value;
            end
        end
        if (i_cmd.read) begin
            r_rd_data <= mem[r_ptr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_threshold <= THRESHOLD_RST;
            r_capacity  <= CAPACITY_RST;
            r_small     <= '0;
            r_large     <= '0;
            r_overflow  <= 1'b0;
            r_ptr       <= '0;
            r_phase     <= 1'b0;
            r_out_large <= 1'b0;
            r_out_last  <= 1'b0;
        end else begin
            if (i_cfg_we && (i_cfg_index == REG_THRESHOLD)) begin
                r_threshold <= i_cfg_data[VALUE_W-1:0];
            end
            if (w_cap_write) begin
                r_capacity <= i_cfg_data[CAP_W-1:0];
            end
            if (w_cap_write || i_cmd.clear) begin
                r_small    <= '0;
                r_large    <= '0;
                r_overflow <= 1'b0;
            end else if (i_cmd.push) begin
                if (w_full) begin
                    r_overflow <= 1'b1;
                end else if (w_to_large) begin
                    r_large <= r_large + CW'(1);
                end else begin
                    r_small <= r_small + CW'(1);
                end
            end
            if (i_cmd.start) begin
                if (r_small != '0) begin
                    r_phase <= 1'b0;
                    r_ptr   <= AW'(r_small - CW'(1));
                end else begin
                    r_phase <= 1'b1;
                    r_ptr   <= w_large_base[AW-1:0];
                end
            end else if (i_cmd.advance) begin
                if (!r_phase) begin
                    if (r_ptr == '0) begin
                        r_phase <= 1'b1;
                        r_ptr   <= w_large_base[AW-1:0];
                    end else begin
                        r_ptr <= r_ptr - AW'(1);
                    end
                end else begin
                    r_ptr <= r_ptr + AW'(1);
                end
            end
            if (i_cmd.read) begin
                r_out_large <= r_phase;
                if (r_phase) begin
                    r_out_last <= (r_ptr == w_cap_m1[AW-1:0]);
                end else begin
                    r_out_last <= (r_ptr == '0) && (r_large == '0);
                end
            end
        end
    end

    assign o_status.empty = (w_total == '0);
    assign o_status.last  = r_out_last;
    assign o_item_value   = r_rd_data;
    assign o_from_large   = r_out_large;
    assign o_last         = r_out_last;
    assign o_dropped      = r_overflow;

endmodule

[sv/dual_stack_threshold_sorter.sv]
// Top level of the dual stack threshold sorter: controller, datapath and checks.
//
// Items arrive on i_in as transactions carrying op and value. A push (op 0)
// stores its value: values above the threshold register go to the large
// stack, which grows down from the capacity limit, all others to the small
// stack at the bottom. A push when both stacks together hold the capacity
// is lost and sets the dropped flag. A finish (op 1) drains the small stack
// top first, then the large stack from its top toward the capacity limit,
// one result transaction on o_out per entry. Each result is a memory read
// followed by showing the registered result, and the block takes no input
// until the drain ends. While o_out is stalled the result is held and no
// input is taken. The final result carries last, and both stacks are then
// emptied. A finish with both stacks empty produces nothing and only
// clears the dropped flag. Reset sets threshold to 1000, capacity to 64
// and empties both stacks. Register writes on the configuration port are
// registered; a capacity write also empties both stacks.
module dual_stack_threshold_sorter import dsts_pkg::*; #(
    parameter int DEPTH = DEFAULT_DEPTH
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    dsts_in_if.sink               i_in,
    dsts_out_if.source            o_out,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    t_dp_cmd    w_cmd;
    t_dp_status w_status;

    dsts_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .i_in_op     (i_in.op),
        .i_out_ready (o_out.ready),
        .i_status    (w_status),
        .o_in_ready  (i_in.ready),
        .o_out_valid (o_out.valid),
        .o_cmd       (w_cmd)
    );

    dsts_datapath #(
        .DEPTH (DEPTH)
    ) u_datapath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_value      (i_in.value),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .i_cmd        (w_cmd),
        .o_status     (w_status),
        .o_item_value (o_out.item_value),
        .o_from_large (o_out.from_large),
        .o_last       (o_out.last),
        .o_dropped    (o_out.dropped)
    );

    a_no_input_while_showing : assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid |-> !i_in.ready
    ) else $error("Input accepted while a result is pending.");

    a_busy_after_middle_result : assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.ready && !o_out.last) |=> (!i_in.ready && !o_out.valid)
    ) else $error("Drain stopped before the last result.");

    a_idle_after_last : assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.ready && o_out.last) |=> (i_in.ready && !o_out.dropped)
    ) else $error("Block not emptied after the last result.");

endmodule
